[sv/assert_macros.svh]
// Assertion macros shared by the button tracker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset
`define BPLT_ASSERT_IMP(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never be true outside reset
`define BPLT_ASSERT_NEVER(name, ck, rn, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error(msg);

`endif

[sv/bplt_pkg.sv]
// Package for the button long-press tracker: widths, event and state codes,
// command and state machine types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bplt_pkg;

    localparam int BTN_W       = 4;
    localparam int TICK_W      = 32;
    localparam int THR_W       = 16;
    localparam int EV_W        = 2;
    localparam int ST_W        = 2;
    localparam int MAX_BUTTONS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [THR_W-1:0] THR_RESET = 16'd1000;

    // Event codes
    localparam logic [EV_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [EV_W-1:0] EV_LONG    = 2'd1;
    localparam logic [EV_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EV_W-1:0] EV_BAD     = 2'd3;

    // Per-button state codes
    localparam logic [ST_W-1:0] ST_IDLE    = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESSED = 2'd1;
    localparam logic [ST_W-1:0] ST_LONG    = 2'd2;

    // Command kinds produced by the front end
    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_BAD    = 2'd1,
        CMD_POLL   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [BTN_W-1:0]   button;
        logic               pressed;
        logic [TICK_W-1:0]  tick;
    } cmd_t;

    // Back end sequencer
    typedef enum logic [2:0] {
        S_WAIT  = 3'b001,
        S_SCAN  = 3'b010,
        S_DRAIN = 3'b100
    } back_fsm_t;

endpackage

`default_nettype wire

[sv/button_press_long_press_tracker.sv]
// Top level of the button long-press tracker: front end, command queue, back end.
// Depends on bplt_pkg, bplt_front, bplt_queue and bplt_back.
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_data[15:0]      | in
//  in      | in_valid, in_ready, mode, button,         | in
//          | pressed, tick_ms[31:0]                    |
//  out     | out_valid, out_ready, event_res, event_button, last | out
//
// An update is handled in the wait state; a poll runs a scan that reads one
// button entry per cycle while the output does not hold it.
// A two-entry command queue lets the front accept while the back works.
// rst_n clears all buttons to idle and the threshold to 1000 ms.
// A stalled output holds the scan whenever a further long press is found.
`timescale 1ns / 1ps
`default_nettype none

module button_press_long_press_tracker #(
    parameter int NUM_BUTTONS = bplt_pkg::MAX_BUTTONS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [bplt_pkg::THR_W-1:0]  cfg_data,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire                         mode,
    input  wire  [bplt_pkg::BTN_W-1:0]  button,
    input  wire                         pressed,
    input  wire  [bplt_pkg::TICK_W-1:0] tick_ms,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [bplt_pkg::EV_W-1:0]   event_res,
    output logic [bplt_pkg::BTN_W-1:0]  event_button,
    output logic                        last
);
    import bplt_pkg::*;

    logic q_full, q_push, q_pop, q_not_empty;
    cmd_t push_cmd, pop_cmd;

    // Threshold writes are always taken
    assign cfg_ready = 1'b1;

    bplt_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .button   (button),
        .pressed  (pressed),
        .tick_ms  (tick_ms),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    bplt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_not_empty)
    );

    bplt_back #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .q_not_empty  (q_not_empty),
        .q_cmd        (pop_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .event_res    (event_res),
        .event_button (event_button),
        .last         (last)
    );

endmodule

`default_nettype wire

[sv/bplt_queue.sv]
// Short command queue between the front end and the back end.
// Depends on bplt_pkg (cmd_t, QUEUE_DEPTH) and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bplt_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  bplt_pkg::cmd_t  push_cmd,
    output logic            full,
    input  wire             pop,
    output bplt_pkg::cmd_t  pop_cmd,
    output logic            not_empty
);
    import bplt_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    `BPLT_ASSERT_NEVER(a_q_overfill, clk, rst_n, count_reg > QCNT_W'(QUEUE_DEPTH), "queue count exceeds depth")
    `BPLT_ASSERT_IMP(a_q_ptr_gap, clk, rst_n, not_empty && !full, wr_ptr_reg != rd_ptr_reg, "queue pointers disagree with count")

endmodule

`default_nettype wire

[sv/bplt_front.sv]
// Front end: accepts input transactions and classifies them into commands.
// Depends on bplt_pkg (cmd_t, cmd_kind_t, widths).
`timescale 1ns / 1ps
`default_nettype none

module bplt_front #(
    parameter int NUM_BUTTONS = bplt_pkg::MAX_BUTTONS
) (
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire                          mode,
    input  wire  [bplt_pkg::BTN_W-1:0]   button,
    input  wire                          pressed,
    input  wire  [bplt_pkg::TICK_W-1:0]  tick_ms,
    input  wire                          q_full,
    output logic                         q_push,
    output bplt_pkg::cmd_t               q_cmd
);
    import bplt_pkg::*;

    logic bad_id;

    // Out-of-range id check
    assign bad_id   = ({1'b0, button} >= (BTN_W + 1)'(NUM_BUTTONS));
    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Classify the transaction
    always_comb
    begin
        q_cmd.button  = button;
        q_cmd.pressed = pressed;
        q_cmd.tick    = tick_ms;
        if (mode)
        begin
            q_cmd.kind = CMD_POLL;
        end
        else if (bad_id)
        begin
            q_cmd.kind = CMD_BAD;
        end
        else
        begin
            q_cmd.kind = CMD_UPDATE;
        end
    end

endmodule

`default_nettype wire

[sv/bplt_back.sv]
// Back end: button state bank, press timestamps, poll scan sequencer and
// output register. Depends on bplt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bplt_back #(
    parameter int NUM_BUTTONS = bplt_pkg::MAX_BUTTONS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_valid,
    input  wire  [bplt_pkg::THR_W-1:0]  cfg_data,
    input  wire                         q_not_empty,
    input  bplt_pkg::cmd_t              q_cmd,
    output logic                        q_pop,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [bplt_pkg::EV_W-1:0]   event_res,
    output logic [bplt_pkg::BTN_W-1:0]  event_button,
    output logic                        last
);
    import bplt_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    back_fsm_t          fsm_reg, fsm_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [TICK_W-1:0]  tick_reg, tick_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [BTN_W-1:0]   pend_button_reg, pend_button_next;
    logic [THR_W-1:0]   thr_reg;
    logic [ST_W-1:0]    btn_state_reg [NUM_BUTTONS];
    logic [TICK_W-1:0]  press_time_reg [NUM_BUTTONS];

    logic               out_valid_reg, out_valid_next;
    logic [EV_W-1:0]    res_reg, res_next;
    logic [BTN_W-1:0]   obtn_reg, obtn_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic [IDX_W-1:0]   rd_idx;
    logic [ST_W-1:0]    rd_state;
    logic [TICK_W-1:0]  held;
    logic               promote;
    logic               st_we, pt_we;
    logic [ST_W-1:0]    st_wdata;

    assign out_valid    = out_valid_reg;
    assign event_res    = res_reg;
    assign event_button = obtn_reg;
    assign last         = last_reg;

    // Entry lookup and long-press test
    assign out_free = !out_valid_reg || out_ready;
    assign rd_idx   = (fsm_reg == S_SCAN) ? idx_reg : q_cmd.button[IDX_W-1:0];
    assign rd_state = btn_state_reg[rd_idx];
    assign held     = tick_reg - press_time_reg[rd_idx];
    assign promote  = (rd_state == ST_PRESSED) && (held >= {{(TICK_W - THR_W){1'b0}}, thr_reg});

    // Sequencer
    always_comb
    begin
        fsm_next         = fsm_reg;
        idx_next         = idx_reg;
        tick_next        = tick_reg;
        pend_valid_next  = pend_valid_reg;
        pend_button_next = pend_button_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        res_next         = res_reg;
        obtn_next        = obtn_reg;
        last_next        = last_reg;
        q_pop            = 1'b0;
        st_we            = 1'b0;
        pt_we            = 1'b0;
        st_wdata         = ST_IDLE;
        case (fsm_reg)
            S_WAIT:
            begin
                if (q_not_empty && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        CMD_BAD:
                        begin
                            out_valid_next = 1'b1;
                            res_next       = EV_BAD;
                            obtn_next      = q_cmd.button;
                            last_next      = 1'b1;
                        end
                        CMD_UPDATE:
                        begin
                            if (q_cmd.pressed && (rd_state == ST_IDLE))
                            begin
                                st_we          = 1'b1;
                                st_wdata       = ST_PRESSED;
                                pt_we          = 1'b1;
                                out_valid_next = 1'b1;
                                res_next       = EV_PRESS;
                                obtn_next      = q_cmd.button;
                                last_next      = 1'b1;
                            end
                            else if (!q_cmd.pressed && (rd_state != ST_IDLE))
                            begin
                                st_we          = 1'b1;
                                st_wdata       = ST_IDLE;
                                out_valid_next = 1'b1;
                                res_next       = EV_RELEASE;
                                obtn_next      = q_cmd.button;
                                last_next      = 1'b1;
                            end
                        end
                        CMD_POLL:
                        begin
                            tick_next       = q_cmd.tick;
                            idx_next        = '0;
                            pend_valid_next = 1'b0;
                            fsm_next        = S_SCAN;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Hold the scan when a second event finds the output busy
                if (!(promote && pend_valid_reg && !out_free))
                begin
                    if (promote)
                    begin
                        st_we    = 1'b1;
                        st_wdata = ST_LONG;
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            res_next       = EV_LONG;
                            obtn_next      = pend_button_reg;
                            last_next      = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_button_next = BTN_W'(idx_reg);
                    end
                    if (idx_reg == IDX_W'(NUM_BUTTONS - 1))
                    begin
                        fsm_next = S_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DRAIN:
            begin
                if (!pend_valid_reg)
                begin
                    fsm_next = S_WAIT;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    res_next        = EV_LONG;
                    obtn_next       = pend_button_reg;
                    last_next       = 1'b1;
                    pend_valid_next = 1'b0;
                    fsm_next        = S_WAIT;
                end
            end
            default:
            begin
                fsm_next = S_WAIT;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg        <= S_WAIT;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            thr_reg        <= THR_RESET;
        end
        else
        begin
            fsm_reg        <= fsm_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
        end
    end

    // Button state bank
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                btn_state_reg[i] <= ST_IDLE;
            end
        end
        else if (st_we)
        begin
            btn_state_reg[rd_idx] <= st_wdata;
        end
    end

    // Payload registers and timestamps
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        tick_reg        <= tick_next;
        pend_button_reg <= pend_button_next;
        res_reg         <= res_next;
        obtn_reg        <= obtn_next;
        last_reg        <= last_next;
        if (pt_we)
        begin
            press_time_reg[rd_idx] <= q_cmd.tick;
        end
    end

    `BPLT_ASSERT_NEVER(a_pend_in_wait, clk, rst_n, (fsm_reg == S_WAIT) && pend_valid_reg, "pending long press left after scan")
    `BPLT_ASSERT_IMP(a_nonlast_busy, clk, rst_n, out_valid_reg && !last_reg, fsm_reg != S_WAIT, "non-final event while sequencer idle")

endmodule

`default_nettype wire

[verif/tb_button_press_long_press_tracker.sv]
// Self-checking testbench for button_press_long_press_tracker.
// Holds a scoreboard class that predicts button events, plus the driving tasks.
// Depends on bplt_pkg and the tracker RTL.
`timescale 1ns / 1ps

import bplt_pkg::*;

localparam logic MODE_UPDATE = 1'b0;
localparam logic MODE_POLL   = 1'b1;

typedef struct packed {
    logic [EV_W-1:0]  code;
    logic [BTN_W-1:0] ev_button;
    logic             is_last;
} bank_event_t;

// Predicts the event stream of the button bank and checks what comes out
class bank_event_scoreboard;
    logic [ST_W-1:0]   btn_state  [MAX_BUTTONS];
    logic [TICK_W-1:0] held_since [MAX_BUTTONS];
    logic [THR_W-1:0]  long_thr;
    bank_event_t       due_events [$];
    int                bank_size;
    int                mismatches;

    function new(int buttons);
        bank_size  = buttons;
        mismatches = 0;
        long_thr   = THR_RESET;
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            btn_state[i]  = ST_IDLE;
            held_since[i] = '0;
        end
    endfunction

    function void set_threshold(input logic [THR_W-1:0] value);
        long_thr = value;
    endfunction

    function int pending();
        return due_events.size();
    endfunction

    // Work out the events caused by one accepted input transaction
    function void note_input(input logic kind, input logic [BTN_W-1:0] idx,
                             input logic level, input logic [TICK_W-1:0] tick);
        bank_event_t       fresh [$];
        bank_event_t       ev;
        logic [TICK_W-1:0] held;
        ev.is_last = 1'b0;
        if (kind == MODE_UPDATE)
        begin
            ev.ev_button = idx;
            if (int'(idx) >= bank_size)
            begin
                ev.code = EV_BAD;
                fresh.push_back(ev);
            end
            else if (level)
            begin
                // a press only counts from idle
                if (btn_state[idx] == ST_IDLE)
                begin
                    btn_state[idx]  = ST_PRESSED;
                    held_since[idx] = tick;
                    ev.code = EV_PRESS;
                    fresh.push_back(ev);
                end
            end
            else if (btn_state[idx] == ST_PRESSED || btn_state[idx] == ST_LONG)
            begin
                btn_state[idx] = ST_IDLE;
                ev.code = EV_RELEASE;
                fresh.push_back(ev);
            end
        end
        else
        begin
            // scan in index order, held time wraps modulo 2^32
            for (int i = 0; i < bank_size; i++)
            begin
                held = tick - held_since[i];
                if (btn_state[i] == ST_PRESSED && held >= long_thr)
                begin
                    btn_state[i] = ST_LONG;
                    ev.code      = EV_LONG;
                    ev.ev_button = BTN_W'(i);
                    fresh.push_back(ev);
                end
                if (btn_state[i] == ST_IDLE)
                    held_since[i] = '0;
            end
        end
        if (fresh.size() > 0)
            fresh[fresh.size() - 1].is_last = 1'b1;
        foreach (fresh[k])
            due_events.push_back(fresh[k]);
    endfunction

    // Compare one accepted output transaction with the oldest prediction
    function void check_event(input logic [EV_W-1:0] code, input logic [BTN_W-1:0] idx,
                              input logic lst);
        bank_event_t got;
        bank_event_t want;
        got.code      = code;
        got.ev_button = idx;
        got.is_last   = lst;
        if (due_events.size() == 0)
        begin
            if (mismatches < 10)
                $display("unexpected event: res=%0d button=%0d last=%0b", code, idx, lst);
            mismatches++;
        end
        else
        begin
            want = due_events.pop_front();
            if (want !== got)
            begin
                if (mismatches < 10)
                    $display("mismatch: expected res=%0d button=%0d last=%0b, got res=%0d button=%0d last=%0b",
                             want.code, want.ev_button, want.is_last, code, idx, lst);
                mismatches++;
            end
        end
    endfunction
endclass

module tb_button_press_long_press_tracker;

    localparam int NUM_BTN        = MAX_BUTTONS;
    localparam int SETTLE_CYCLES  = 3 * (NUM_BTN + 2) + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               cfg_valid    = 1'b0;
    logic               cfg_ready;
    logic [THR_W-1:0]   cfg_data     = '0;
    logic               in_valid     = 1'b0;
    logic               in_ready;
    logic               mode         = 1'b0;
    logic [BTN_W-1:0]   button       = '0;
    logic               pressed      = 1'b0;
    logic [TICK_W-1:0]  tick_ms      = '0;
    logic               out_valid;
    logic               out_ready    = 1'b0;
    logic [EV_W-1:0]    event_res;
    logic [BTN_W-1:0]   event_button;
    logic               last;

    bank_event_scoreboard board;

    // stimulus-side view of which buttons are held, used only to steer stimulus
    bit                 held_btn  [MAX_BUTTONS];
    logic [TICK_W-1:0]  held_tick [MAX_BUTTONS];
    logic [THR_W-1:0]   cur_thr     = THR_RESET;
    int                 burst_left  = 0;
    int                 quiet_cycles = 0;
    int unsigned        stall_count = 0;
    logic [1:0]         stall_style = 2'd0;

    button_press_long_press_tracker #(
        .NUM_BUTTONS(NUM_BTN)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .button      (button),
        .pressed     (pressed),
        .tick_ms     (tick_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_res   (event_res),
        .event_button(event_button),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Output stall pattern: picks a new random style whenever stall_count[5:0] is zero
    always @(posedge clk)
    begin
        stall_count <= stall_count + 1;
        if (stall_count[5:0] == 6'd0)
            stall_style <= 2'($urandom_range(0, 3));
        case (stall_style)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= (stall_count % 5 == 0);
            default: out_ready <= stall_count[4];
        endcase
    end

    // Transaction monitor feeding the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                board.set_threshold(cfg_data);
            if (in_valid && in_ready)
                board.note_input(mode, button, pressed, tick_ms);
            if (out_valid && out_ready)
                board.check_event(event_res, event_button, last);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Send one input transaction; bursts of random length with random gaps
    task automatic send_item(input logic kind, input logic [BTN_W-1:0] idx,
                             input logic level, input logic [TICK_W-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        mode     <= kind;
        button   <= idx;
        pressed  <= level;
        tick_ms  <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic do_press(input logic [BTN_W-1:0] b, input logic [TICK_W-1:0] t);
        if (!held_btn[b])
        begin
            held_btn[b]  = 1'b1;
            held_tick[b] = t;
        end
        send_item(MODE_UPDATE, b, 1'b1, t);
    endtask

    task automatic do_release(input logic [BTN_W-1:0] b, input logic [TICK_W-1:0] t);
        held_btn[b] = 1'b0;
        send_item(MODE_UPDATE, b, 1'b0, t);
    endtask

    // button and level are don't-care on a poll, so they carry random bits
    task automatic do_poll(input logic [TICK_W-1:0] t);
        send_item(MODE_POLL, BTN_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), t);
    endtask

    // Threshold write, only once the block has drained and gone quiet
    task automatic write_threshold(input logic [THR_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        cur_thr    = value;
        burst_left = 0;
    endtask

    // Mostly picks a button in the wanted held/idle condition
    function automatic logic [BTN_W-1:0] pick_button(input bit want_held);
        int start;
        start = $urandom_range(0, 15);
        if ($urandom_range(0, 99) < 85)
            for (int k = 0; k < 16; k++)
                if (held_btn[(start + k) % 16] == want_held)
                    return BTN_W'((start + k) % 16);
        return BTN_W'(start);
    endfunction

    // Release what is held, then press the whole bank at one tick
    task automatic press_whole_bank(input logic [TICK_W-1:0] t);
        for (int b = 0; b < NUM_BTN; b++)
            if (held_btn[b])
                do_release(BTN_W'(b), t);
        for (int b = 0; b < NUM_BTN; b++)
            do_press(BTN_W'(b), t);
    endtask

    // Random press/release/poll traffic on an advancing tick
    task automatic run_session(input int target);
        int                done_count;
        int                pick;
        bit                noise;
        logic [BTN_W-1:0]  b;
        logic [TICK_W-1:0] now;
        logic [TICK_W-1:0] t;
        done_count = 0;
        if ($urandom_range(0, 2) == 0)
            now = 32'hFFFF_FFFF - $urandom_range(0, 4 * cur_thr + 50);
        else
            now = $urandom;
        while (done_count < target)
        begin
            now   = now + $urandom_range(0, cur_thr / 2 + 2);
            noise = ($urandom_range(0, 99) < 8);
            t     = noise ? $urandom : now;
            pick  = $urandom_range(0, 99);
            if (pick < 40)
            begin
                b = pick_button(1'b0);
                if (!held_btn[b])
                    done_count++;
                do_press(b, t);
            end
            else if (pick < 65)
            begin
                b = pick_button(1'b1);
                if (held_btn[b])
                    done_count++;
                do_release(b, t);
            end
            else
            begin
                // sometimes poll right at a held button's threshold edge
                b = pick_button(1'b1);
                if (!noise && held_btn[b] && $urandom_range(0, 2) == 0)
                    t = held_tick[b] + cur_thr - $urandom_range(0, 1);
                done_count++;
                do_poll(t);
            end
        end
    endtask

    initial
    begin
        logic [TICK_W-1:0] base;
        board = new(NUM_BTN);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: default threshold of 1000 ms
        do_poll(32'd0);
        do_release(4'd0, 32'd10);
        do_press(4'd0, 32'd100);
        do_press(4'd0, 32'd200);
        do_poll(32'd1099);
        do_poll(32'd1100);
        do_poll(32'd5000);
        do_press(4'd15, 32'hFFFF_FF00);
        do_press(4'd7, 32'hFFFF_FFFF);
        do_poll(32'h0000_02E7);
        do_poll(32'h0000_02E8);
        do_poll(32'h0000_03E7);
        do_release(4'd0, 32'h0000_0400);
        do_release(4'd0, 32'h0000_0401);
        do_release(4'd15, 32'h0000_0402);
        do_press(4'd3, 32'h1234_5678);
        do_press(4'd9, 32'h1234_5678);
        do_press(4'd12, 32'h1234_5000);
        do_poll(32'h1234_5A5F);
        do_poll(32'h1234_5A60);
        do_release(4'd3, 32'h1234_6000);
        do_release(4'd7, 32'h1234_6000);
        do_release(4'd9, 32'h1234_6000);
        do_release(4'd12, 32'h1234_6000);
        // tick going backwards wraps to a huge held time
        do_press(4'd5, 32'h8000_0000);
        do_poll(32'h7FFF_FFFF);

        // Zero threshold: every pressed button goes long at the next poll
        write_threshold(16'd0);
        base = $urandom;
        press_whole_bank(base);
        do_poll(base);
        run_session(15);

        // Largest threshold, full bank promoted in one poll
        write_threshold(16'hFFFF);
        base = $urandom;
        press_whole_bank(base);
        do_poll(base + 32'd65534);
        do_poll(base + 32'd65535);
        run_session(30);

        write_threshold(16'd1);
        run_session(20);

        repeat (3)
        begin
            write_threshold(THR_W'($urandom_range(2, 300)));
            run_session(20);
        end

        write_threshold(THR_RESET);
        run_session(15);

        // Drain and let the last scan finish
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/bplt_pkg.sv
sv/bplt_queue.sv
sv/bplt_front.sv
sv/bplt_back.sv
sv/button_press_long_press_tracker.sv
verif/tb_button_press_long_press_tracker.sv
